>>> hdl/nrm_pkg.sv
// nrm_pkg: shared widths, datapath command codes and control structs
// for the normalized rmse meter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nrm_pkg;

    // sample and count sizing
    localparam int SAMPLE_WIDTH = 16;
    localparam int COUNT_LOG2   = 16;
    localparam int COUNT_W      = COUNT_LOG2 + 1;
    localparam int DIFF_W       = SAMPLE_WIDTH + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int SUM_W        = 50;

    // result path sizing
    localparam int WORK_W       = 64;
    localparam int ROOT_W       = 32;
    localparam int FRAC_SHIFT   = 16;
    localparam int RATIO_SHIFT  = 8;
    localparam int Q2_W         = ROOT_W + RATIO_SHIFT;
    localparam int RATIO_W      = 24;
    localparam int OUT_COUNT_W  = 17;
    localparam int DIV_W        = (COUNT_W > DIFF_W) ? COUNT_W : DIFF_W;
    localparam int SQR_W        = ROOT_W + 2;
    localparam int STEP_W       = 7;

    // step counts of the serial phases
    localparam int DIV_STEPS    = WORK_W;
    localparam int SQRT_STEPS   = WORK_W / 2;
    localparam int DIV2_STEPS   = Q2_W;

    // datapath commands
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIV_STEP,
        OP_SQRT_STEP,
        OP_DIV2_LOAD,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        logic accept;
        op_t  op;
    } nrm_cmd_t;

    typedef struct packed {
        logic range_zero;
    } nrm_status_t;

endpackage

`default_nettype wire

>>> hdl/nrm_datapath.sv
// nrm_datapath: accumulators, shared serial divider and square root,
// and output registers; depends on nrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrm_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic signed [nrm_pkg::SAMPLE_WIDTH-1:0] s_expected_sample,
    input  wire logic signed [nrm_pkg::SAMPLE_WIDTH-1:0] s_actual_sample,
    input  wire logic                                s_last_sample,
    input  wire nrm_pkg::nrm_cmd_t                   cmd,
    output nrm_pkg::nrm_status_t                     status,
    output logic [nrm_pkg::RATIO_W-1:0]              m_error_ratio,
    output logic                                     m_zero_range,
    output logic [nrm_pkg::OUT_COUNT_W-1:0]          m_sample_count
);

    localparam int SW = nrm_pkg::SAMPLE_WIDTH;

    // accumulator state
    logic [nrm_pkg::SUM_W-1:0]   sum_reg;
    logic [nrm_pkg::COUNT_W-1:0] cnt_reg;
    logic signed [SW-1:0]        min_reg;
    logic signed [SW-1:0]        max_reg;

    // serial unit state
    logic [nrm_pkg::WORK_W-1:0]  work_reg;
    logic [nrm_pkg::DIV_W-1:0]   div_rem_reg;
    logic [nrm_pkg::DIV_W-1:0]   divisor_reg;
    logic [nrm_pkg::SQR_W-1:0]   sq_rem_reg;
    logic [nrm_pkg::ROOT_W-1:0]  root_reg;
    logic [nrm_pkg::COUNT_W-1:0] count_snap_reg;
    logic [nrm_pkg::DIFF_W-1:0]  range_snap_reg;
    logic                        zero_snap_reg;

    logic [nrm_pkg::RATIO_W-1:0]     ratio_out_reg;
    logic                            zero_out_reg;
    logic [nrm_pkg::OUT_COUNT_W-1:0] count_out_reg;

    logic signed [nrm_pkg::DIFF_W-1:0] diff;
    logic [nrm_pkg::DIFF_W-1:0]        mag;
    logic [nrm_pkg::SQ_W-1:0]          sq;
    logic                              full;
    logic [nrm_pkg::SUM_W-1:0]         sum_next;
    logic [nrm_pkg::COUNT_W-1:0]       cnt_next;
    logic signed [SW-1:0]              min_next;
    logic signed [SW-1:0]              max_next;
    logic [nrm_pkg::DIFF_W-1:0]        range_next;
    logic [nrm_pkg::DIV_W:0]           div_trial;
    logic                              div_fit;
    logic [nrm_pkg::SQR_W-1:0]         sq_shift;
    logic [nrm_pkg::SQR_W-1:0]         sq_trial;
    logic                              sq_fit;
    logic [nrm_pkg::RATIO_W-1:0]       ratio_sat;

    // squared difference and next accumulator values
    always_comb begin
        diff       = {s_expected_sample[SW-1], s_expected_sample}
                   - {s_actual_sample[SW-1], s_actual_sample};
        mag        = diff[nrm_pkg::DIFF_W-1] ? (-diff) : diff;
        sq         = mag * mag;
        full       = cnt_reg[nrm_pkg::COUNT_LOG2];
        sum_next   = full ? sum_reg : (sum_reg + nrm_pkg::SUM_W'(sq));
        cnt_next   = full ? cnt_reg : (cnt_reg + 1'b1);
        min_next   = (!full && (s_expected_sample < min_reg)) ? s_expected_sample : min_reg;
        max_next   = (!full && (s_expected_sample > max_reg)) ? s_expected_sample : max_reg;
        range_next = {max_next[SW-1], max_next} - {min_next[SW-1], min_next};
        status.range_zero = (range_next == '0);
    end

    // restoring divide step and square root step
    always_comb begin
        div_trial = {div_rem_reg, work_reg[nrm_pkg::WORK_W-1]};
        div_fit   = (div_trial >= {1'b0, divisor_reg});
        sq_shift  = {sq_rem_reg[nrm_pkg::SQR_W-3:0], work_reg[nrm_pkg::WORK_W-1 -: 2]};
        sq_trial  = {root_reg, 2'b01};
        sq_fit    = (sq_shift >= sq_trial);
        ratio_sat = (|work_reg[nrm_pkg::Q2_W-1:nrm_pkg::RATIO_W])
                  ? {nrm_pkg::RATIO_W{1'b1}} : work_reg[nrm_pkg::RATIO_W-1:0];
    end

    // accumulators, cleared after the closing beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
            min_reg <= {1'b0, {(SW-1){1'b1}}};
            max_reg <= {1'b1, {(SW-1){1'b0}}};
        end else if (cmd.accept) begin
            if (s_last_sample) begin
                sum_reg <= '0;
                cnt_reg <= '0;
                min_reg <= {1'b0, {(SW-1){1'b1}}};
                max_reg <= {1'b1, {(SW-1){1'b0}}};
            end else begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    // serial unit and output registers
    always_ff @(posedge aclk) begin
        if (cmd.accept && s_last_sample) begin
            work_reg       <= {sum_next[nrm_pkg::WORK_W-nrm_pkg::FRAC_SHIFT-1:0],
                               {nrm_pkg::FRAC_SHIFT{1'b0}}};
            div_rem_reg    <= '0;
            sq_rem_reg     <= '0;
            root_reg       <= '0;
            divisor_reg    <= nrm_pkg::DIV_W'(cnt_next);
            count_snap_reg <= cnt_next;
            range_snap_reg <= range_next;
            zero_snap_reg  <= status.range_zero;
        end else begin
            case (cmd.op)
                nrm_pkg::OP_DIV_STEP: begin
                    div_rem_reg <= div_fit ? nrm_pkg::DIV_W'(div_trial - {1'b0, divisor_reg})
                                           : div_trial[nrm_pkg::DIV_W-1:0];
                    work_reg    <= {work_reg[nrm_pkg::WORK_W-2:0], div_fit};
                end
                nrm_pkg::OP_SQRT_STEP: begin
                    sq_rem_reg <= sq_fit ? (sq_shift - sq_trial) : sq_shift;
                    root_reg   <= {root_reg[nrm_pkg::ROOT_W-2:0], sq_fit};
                    work_reg   <= {work_reg[nrm_pkg::WORK_W-3:0], 2'b00};
                end
                nrm_pkg::OP_DIV2_LOAD: begin
                    work_reg    <= {root_reg, {nrm_pkg::RATIO_SHIFT{1'b0}},
                                    {(nrm_pkg::WORK_W-nrm_pkg::Q2_W){1'b0}}};
                    div_rem_reg <= '0;
                    divisor_reg <= nrm_pkg::DIV_W'(range_snap_reg);
                end
                nrm_pkg::OP_OUT_LOAD: begin
                    ratio_out_reg <= zero_snap_reg ? '0 : ratio_sat;
                    zero_out_reg  <= zero_snap_reg;
                    count_out_reg <= nrm_pkg::OUT_COUNT_W'(count_snap_reg);
                end
                default: begin
                end
            endcase
        end
    end

    assign m_error_ratio  = ratio_out_reg;
    assign m_zero_range   = zero_out_reg;
    assign m_sample_count = count_out_reg;

endmodule

`default_nettype wire

>>> hdl/nrm_ctrl.sv
// nrm_ctrl: sequencer for accumulate, divide, root, divide and result beat;
// depends on nrm_pkg
`timescale 1ns / 1ps
`default_nettype none

module nrm_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_last_sample,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire nrm_pkg::nrm_status_t status,
    output nrm_pkg::nrm_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_D2LOAD,
        ST_DIV2,
        ST_DONE
    } state_t;

    state_t                       state_reg;
    logic [nrm_pkg::STEP_W-1:0]   step_reg;
    logic                         m_valid_reg;
    logic                         accept;
    logic                         out_free;

    // command decode
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        accept     = s_valid && s_ready;
        out_free   = !m_valid_reg || m_ready;
        cmd.accept = accept;
        unique case (state_reg)
            ST_DIV:    cmd.op = nrm_pkg::OP_DIV_STEP;
            ST_SQRT:   cmd.op = nrm_pkg::OP_SQRT_STEP;
            ST_D2LOAD: cmd.op = nrm_pkg::OP_DIV2_LOAD;
            ST_DIV2:   cmd.op = nrm_pkg::OP_DIV_STEP;
            ST_DONE:   cmd.op = out_free ? nrm_pkg::OP_OUT_LOAD : nrm_pkg::OP_NONE;
            default:   cmd.op = nrm_pkg::OP_NONE;
        endcase
    end

    // state, step counter and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_last_sample) begin
                        if (status.range_zero) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_DIV;
                            step_reg  <= nrm_pkg::STEP_W'(nrm_pkg::DIV_STEPS - 1);
                        end
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_SQRT;
                        step_reg  <= nrm_pkg::STEP_W'(nrm_pkg::SQRT_STEPS - 1);
                    end
                end
                ST_SQRT: begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_D2LOAD;
                    end
                end
                ST_D2LOAD: begin
                    state_reg <= ST_DIV2;
                    step_reg  <= nrm_pkg::STEP_W'(nrm_pkg::DIV2_STEPS - 1);
                end
                ST_DIV2: begin
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == nrm_pkg::OP_OUT_LOAD) |-> (!m_valid_reg || m_ready))
        else $error("result loaded while previous beat still pending");

    // a closing beat with a nonzero range starts the divide
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_sample && !status.range_zero) |=> (state_reg == ST_DIV))
        else $error("closing beat did not start the divide");

    // root phase never runs past its step count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (step_reg < nrm_pkg::STEP_W'(nrm_pkg::SQRT_STEPS)))
        else $error("root step counter out of range");

    // no input is taken while a set is being finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last_sample) |=> !s_ready)
        else $error("input accepted during result computation");
`endif

endmodule

`default_nettype wire

>>> hdl/normalized_rmse_meter.sv
// normalized_rmse_meter: rmse over expected range, unsigned Q8.16 result
// a closing beat whose range is zero skips the serial unit and goes straight to the result beat
// throughput: one sample beat per cycle inside a set; the closing beat holds the input
// for the 64-step divide, 32-step root and 40-step divide of the shared serial unit
// reset: synchronous active-low aresetn clears accumulators, sequencer and result valid
// depends on nrm_pkg, nrm_ctrl, nrm_datapath
`timescale 1ns / 1ps
`default_nettype none

module normalized_rmse_meter (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [nrm_pkg::SAMPLE_WIDTH-1:0] s_expected_sample,
    input  wire logic signed [nrm_pkg::SAMPLE_WIDTH-1:0] s_actual_sample,
    input  wire logic                                    s_last_sample,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [nrm_pkg::RATIO_W-1:0]                  m_error_ratio,
    output logic                                         m_zero_range,
    output logic [nrm_pkg::OUT_COUNT_W-1:0]              m_sample_count
);

    nrm_pkg::nrm_cmd_t    cmd;
    nrm_pkg::nrm_status_t status;

    // sequencer
    nrm_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .status        (status),
        .cmd           (cmd)
    );

    // accumulators and serial arithmetic
    nrm_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_expected_sample (s_expected_sample),
        .s_actual_sample   (s_actual_sample),
        .s_last_sample     (s_last_sample),
        .cmd               (cmd),
        .status            (status),
        .m_error_ratio     (m_error_ratio),
        .m_zero_range      (m_zero_range),
        .m_sample_count    (m_sample_count)
    );

endmodule

`default_nettype wire
